/* rtl/core/ofv_pkg.sv */
// shared types, constants and register codes for the octree frustum visibility block
package ofv_pkg;

  localparam int NODE_W      = 12;
  localparam int COORD_W     = 24;
  localparam int DEPTH_W     = 4;
  localparam int STATE_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int EXTENT_W    = 23;
  localparam int EXT_W       = 24;
  localparam int PLANE_COUNT = 4;

  localparam logic [STATE_W-1:0] CLIP_NONE    = 2'b00;
  localparam logic [STATE_W-1:0] CLIP_INSIDE  = 2'b01;
  localparam logic [STATE_W-1:0] CLIP_OUTSIDE = 2'b10;
  localparam logic [STATE_W-1:0] CLIP_PARTIAL = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_LEFT,
    REG_PLANE_RIGHT,
    REG_PLANE_BOTTOM,
    REG_PLANE_TOP,
    REG_LOOK_AXIS,
    REG_NEAR_FAR,
    REG_WORLD_EXTENT
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] nx;
    logic [11:0] ny;
    logic [11:0] nz;
    logic [27:0] w;
  } plane_t;

  typedef struct packed {
    plane_t [PLANE_COUNT-1:0] plane;
    logic [15:0]              lx;
    logic [15:0]              ly;
    logic [15:0]              lz;
    logic [31:0]              near_dist;
    logic [31:0]              far_dist;
    logic [EXTENT_W-1:0]      world_extent;
  } cfg_t;

endpackage

/* rtl/core/octree_frustum_visibility_top.sv */
// top level: handshake, visibility store with forwarding, clip pipeline
//
//   channel | ports         | moves
//   --------+---------------+-----------------------------------------------
//   input   | in_valid/ready| node index, parent index, root flag, centre, depth
//   result  | out_valid/rdy | node index, two-bit clip state
//   config  | cfg_we        | register index and 64-bit data, one write a cycle
//
// one node a cycle while the result side is not stalled; each accepted
// transaction passes input register, product stage, sum stage, result register
// a stalled result freezes the whole pipeline and drops in_ready
// reset clears the valid bits and the config registers; the data registers and the store are not cleared
// parent states still in flight are forwarded from the commit to the younger stages
module octree_frustum_visibility_top #(
  parameter int NODE_COUNT = 4096,
  parameter int MAX_DEPTH  = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ofv_pkg::NODE_W-1:0]         in_node_index,
  input  logic [ofv_pkg::NODE_W-1:0]         in_parent_index,
  input  logic                               in_is_root,
  input  logic signed [ofv_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [ofv_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [ofv_pkg::COORD_W-1:0] in_center_z,
  input  logic [ofv_pkg::DEPTH_W-1:0]        in_depth,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ofv_pkg::NODE_W-1:0]         out_node_index,
  output logic [ofv_pkg::STATE_W-1:0]        out_clip_state,
  input  logic                               cfg_we,
  input  logic [ofv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ofv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ofv_pkg::*;

  localparam int AW   = $clog2(NODE_COUNT);
  localparam int SH_W = $clog2(MAX_DEPTH + 1);

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  parent;
    logic               root;
    logic [STATE_W-1:0] ps;
  } meta_t;

  cfg_t               cfg;
  logic               adv;
  logic               s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic [NODE_W-1:0]  s1_node_r, s1_parent_r;
  logic               s1_root_r, s1_par_ok_r, s1_fwd_hit_r;
  logic [STATE_W-1:0] s1_fwd_st_r;
  logic signed [COORD_W-1:0] s1_cx_r, s1_cy_r, s1_cz_r;
  logic [EXT_W-1:0]   s1_ext_r;
  logic [EXT_W-1:0]   ext_nxt;
  logic [SH_W-1:0]    depth_cl;
  logic [STATE_W-1:0] s1_ps;
  meta_t              s2_m_r, s3_m_r;
  meta_t              s2_m_nxt, s3_m_nxt;
  logic [STATE_W-1:0] test_st;
  logic [STATE_W-1:0] final_st;
  logic               cm_v, cm_ok;
  logic [STATE_W-1:0] ram_rdata;
  logic [NODE_W-1:0]  out_node_r;
  logic [STATE_W-1:0] out_st_r;

  ofv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign depth_cl = (int'(in_depth) > MAX_DEPTH) ? SH_W'(MAX_DEPTH) : SH_W'(in_depth);
  assign ext_nxt  = EXT_W'({cfg.world_extent, 1'b0} >> depth_cl);

  // a non-root node copies a parent state that is wholly in or wholly out
  assign final_st = (!s3_m_r.root && (s3_m_r.ps == CLIP_INSIDE || s3_m_r.ps == CLIP_OUTSIDE))
                    ? s3_m_r.ps : test_st;

  assign cm_v  = s3_v_r && adv;
  assign cm_ok = int'(s3_m_r.node) < NODE_COUNT;

  assign s1_ps = !s1_par_ok_r ? CLIP_NONE : (s1_fwd_hit_r ? s1_fwd_st_r : ram_rdata);

  always_comb begin
    s2_m_nxt.node   = s1_node_r;
    s2_m_nxt.parent = s1_parent_r;
    s2_m_nxt.root   = s1_root_r;
    s2_m_nxt.ps     = (cm_v && cm_ok && s1_parent_r == s3_m_r.node) ? final_st : s1_ps;
    s3_m_nxt        = s2_m_r;
    if (cm_v && cm_ok && s2_m_r.parent == s3_m_r.node) begin
      s3_m_nxt.ps = final_st;
    end
  end

  ofv_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NODE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (cm_v && cm_ok),
    .waddr (AW'(s3_m_r.node)),
    .wdata (final_st),
    .re    (adv),
    .raddr (AW'(in_parent_index)),
    .rdata (ram_rdata)
  );

  ofv_clip u_clip (
    .clk        (clk),
    .en         (adv),
    .center_x   (s1_cx_r),
    .center_y   (s1_cy_r),
    .center_z   (s1_cz_r),
    .ext        (s1_ext_r),
    .cfg        (cfg),
    .test_state (test_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_node_r    <= in_node_index;
      s1_parent_r  <= in_parent_index;
      s1_root_r    <= in_is_root;
      s1_par_ok_r  <= int'(in_parent_index) < NODE_COUNT;
      // store read and write collide on this edge
      s1_fwd_hit_r <= cm_v && cm_ok && (in_parent_index == s3_m_r.node);
      s1_fwd_st_r  <= final_st;
      s1_cx_r      <= in_center_x;
      s1_cy_r      <= in_center_y;
      s1_cz_r      <= in_center_z;
      s1_ext_r     <= ext_nxt;
      s2_m_r       <= s2_m_nxt;
      s3_m_r       <= s3_m_nxt;
      out_node_r   <= s3_m_r.node;
      out_st_r     <= final_st;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_index = out_node_r;
  assign out_clip_state = out_st_r;

endmodule

/* rtl/core/ofv_ram.sv */
// generic single write port ram with registered read
module ofv_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ofv_cfg.sv */
// configuration registers and field decode
module ofv_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ofv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ofv_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ofv_pkg::cfg_t                  cfg
);
  import ofv_pkg::*;

  logic [CFG_DATA_W-1:0] plane_r [PLANE_COUNT];
  logic [47:0]           look_r;
  logic [63:0]           near_far_r;
  logic [EXTENT_W-1:0]   extent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r    <= '{default: '0};
      look_r     <= '0;
      near_far_r <= '0;
      extent_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index)) inside
        REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_BOTTOM, REG_PLANE_TOP: begin
          plane_r[cfg_index[1:0]] <= cfg_wdata;
        end
        REG_LOOK_AXIS: begin
          look_r <= cfg_wdata[47:0];
        end
        REG_NEAR_FAR: begin
          near_far_r <= cfg_wdata;
        end
        REG_WORLD_EXTENT: begin
          extent_r <= cfg_wdata[EXTENT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      cfg.plane[i].nx = plane_r[i][11:0];
      cfg.plane[i].ny = plane_r[i][23:12];
      cfg.plane[i].nz = plane_r[i][35:24];
      cfg.plane[i].w  = plane_r[i][63:36];
    end
    cfg.lx           = look_r[15:0];
    cfg.ly           = look_r[31:16];
    cfg.lz           = look_r[47:32];
    cfg.near_dist    = near_far_r[31:0];
    cfg.far_dist     = near_far_r[63:32];
    cfg.world_extent = extent_r;
  end

endmodule

/* rtl/core/ofv_clip.sv */
// cube against frustum test: product stage, sum stage, compare logic
module ofv_clip (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [ofv_pkg::COORD_W-1:0] center_x,
  input  logic signed [ofv_pkg::COORD_W-1:0] center_y,
  input  logic signed [ofv_pkg::COORD_W-1:0] center_z,
  input  logic [ofv_pkg::EXT_W-1:0]          ext,
  input  ofv_pkg::cfg_t                      cfg,
  output logic [ofv_pkg::STATE_W-1:0]        test_state
);
  import ofv_pkg::*;

  localparam int PP_W     = 36;
  localparam int LP_W     = 40;
  localparam int MAG_PL_W = 14;
  localparam int MAG_LK_W = 17;
  localparam int R_W      = EXT_W + MAG_PL_W;
  localparam int A_W      = EXT_W + MAG_LK_W;
  localparam int S_W      = 40;
  localparam int C_W      = 42;
  localparam int CMP_W    = 48;

  function automatic logic [15:0] mag16(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  logic signed [PP_W-1:0] pp_nxt [PLANE_COUNT][3];
  logic signed [PP_W-1:0] pp_r   [PLANE_COUNT][3];
  logic [R_W-1:0]         r_nxt  [PLANE_COUNT];
  logic [R_W-1:0]         r_r    [PLANE_COUNT];
  logic [R_W-1:0]         r3_r   [PLANE_COUNT];
  logic signed [LP_W-1:0] lp_nxt [3];
  logic signed [LP_W-1:0] lp_r   [3];
  logic [A_W-1:0]         a_nxt;
  logic [A_W-1:0]         a_r;
  logic [A_W-1:0]         a3_r;
  logic signed [S_W-1:0]  s_nxt  [PLANE_COUNT];
  logic signed [S_W-1:0]  s_r    [PLANE_COUNT];
  logic signed [C_W-1:0]  c_nxt;
  logic signed [C_W-1:0]  c_r;

  // products and extent radii
  always_comb begin
    logic [MAG_PL_W-1:0] pmag;
    logic [MAG_LK_W-1:0] lmag;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      pp_nxt[i][0] = PP_W'($signed(cfg.plane[i].nx) * center_x);
      pp_nxt[i][1] = PP_W'($signed(cfg.plane[i].ny) * center_y);
      pp_nxt[i][2] = PP_W'($signed(cfg.plane[i].nz) * center_z);
      pmag = MAG_PL_W'(mag16(16'($signed(cfg.plane[i].nx))))
           + MAG_PL_W'(mag16(16'($signed(cfg.plane[i].ny))))
           + MAG_PL_W'(mag16(16'($signed(cfg.plane[i].nz))));
      r_nxt[i] = R_W'(ext * pmag);
    end
    lp_nxt[0] = LP_W'($signed(cfg.lx) * center_x);
    lp_nxt[1] = LP_W'($signed(cfg.ly) * center_y);
    lp_nxt[2] = LP_W'($signed(cfg.lz) * center_z);
    lmag = MAG_LK_W'(mag16($signed(cfg.lx)))
         + MAG_LK_W'(mag16($signed(cfg.ly)))
         + MAG_LK_W'(mag16($signed(cfg.lz)));
    a_nxt = A_W'(ext * lmag);
  end

  // centre distances, offset scaled up to Q.18
  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      s_nxt[i] = S_W'(pp_r[i][0]) + S_W'(pp_r[i][1]) + S_W'(pp_r[i][2])
               + (S_W'($signed(cfg.plane[i].w)) <<< 10);
    end
    c_nxt = C_W'(lp_r[0]) + C_W'(lp_r[1]) + C_W'(lp_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      r_r  <= r_nxt;
      lp_r <= lp_nxt;
      a_r  <= a_nxt;
      s_r  <= s_nxt;
      r3_r <= r_r;
      c_r  <= c_nxt;
      a3_r <= a_r;
    end
  end

  always_comb begin
    logic signed [CMP_W-1:0] sv;
    logic signed [CMP_W-1:0] rv;
    logic signed [CMP_W-1:0] cv;
    logic signed [CMP_W-1:0] av;
    logic signed [CMP_W-1:0] closest;
    logic signed [CMP_W-1:0] farthest;
    logic signed [CMP_W-1:0] nearv;
    logic signed [CMP_W-1:0] farv;
    logic                    in_planes;
    logic                    out_any;
    logic                    look_in;
    logic                    look_out;
    in_planes = 1'b1;
    out_any   = 1'b0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      sv = CMP_W'(s_r[i]);
      rv = $signed(CMP_W'(r3_r[i]));
      if (sv < -rv) begin
        in_planes = 1'b0;
      end
      if (sv < rv) begin
        out_any = 1'b1;
      end
    end
    cv       = CMP_W'(c_r);
    av       = $signed(CMP_W'(a3_r));
    closest  = cv - av;
    farthest = cv + av;
    nearv    = CMP_W'($signed(cfg.near_dist)) <<< 14;
    farv     = CMP_W'($signed(cfg.far_dist)) <<< 14;
    look_in  = in_planes && (farthest > nearv) && (closest < farv);
    look_out = in_planes && (!look_in || (farthest > farv) || (closest < nearv));
    test_state = {look_out || out_any, look_in};
  end

endmodule

/* rtl/core/ofv_checker.sv */
// port-level checker for the octree frustum visibility top level, with its bind
module ofv_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ofv_pkg::NODE_W-1:0]  out_node_index,
  input logic [ofv_pkg::STATE_W-1:0] out_clip_state
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_index)
                                && $stable(out_clip_state))
    else $error("result changed while stalled");

  // the pipeline takes a transaction whenever the result side can move
  a_ready_free: assert property (@(posedge clk)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input not ready with a free result register");

  // each accepted transaction reaches the result while the result side drains
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after four cycles");

  // nothing is shown straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind octree_frustum_visibility_top ofv_checker u_checker (.*);

/* test/octree_frustum_visibility_top_tb.sv */
// testbench for the octree frustum visibility block: directed table, random trees, clip predictor
module octree_frustum_visibility_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ofv_pkg::*;

  localparam int NODES     = 4096;
  localparam int DEPTH_MAX = 10;
  localparam int PHASES    = 8;
  localparam int PHASE_ITEMS = 175;

  typedef enum logic [2:0] {
    SET_ZERO,
    SET_HAND,
    SET_ONES,
    SET_EXTREME,
    SET_TAME,
    SET_WILD
  } setting_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  parent;
    logic               root;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [DEPTH_W-1:0] depth;
  } node_txn_t;

  typedef struct packed {
    setting_t            setting;
    node_txn_t           txn;
    logic                typed;
    logic [STATE_W-1:0]  state;
  } dir_row_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [STATE_W-1:0] state;
  } clip_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [NODE_W-1:0]          in_node_index = '0;
  logic [NODE_W-1:0]          in_parent_index = '0;
  logic                       in_is_root = 1'b0;
  logic signed [COORD_W-1:0]  in_center_x = '0;
  logic signed [COORD_W-1:0]  in_center_y = '0;
  logic signed [COORD_W-1:0]  in_center_z = '0;
  logic [DEPTH_W-1:0]         in_depth = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [NODE_W-1:0]          out_node_index;
  logic [STATE_W-1:0]         out_clip_state;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  logic [63:0]         plane_q [PLANE_COUNT];
  logic [47:0]         look_q = '0;
  logic [63:0]         near_far_q = '0;
  logic [EXTENT_W-1:0] extent_q = '0;

  logic [STATE_W-1:0]  vis_shadow [NODES];
  bit                  was_written [NODES];
  logic [NODE_W-1:0]   written_q [$];
  int                  node_cx [NODES];
  int                  node_cy [NODES];
  int                  node_cz [NODES];
  logic [DEPTH_W-1:0]  node_depth [NODES];
  logic [NODE_W-1:0]   lineage [$];
  clip_result_t        clip_expect [$];

  bit quiet = 1'b0;
  int idle_pct = 20;
  int fail_count = 0;

  setting_t phase_plan [PHASES] = '{SET_TAME, SET_WILD, SET_ONES, SET_TAME,
                                    SET_EXTREME, SET_ZERO, SET_TAME, SET_TAME};

  dir_row_t dir_rows [24] = '{
    '{SET_ZERO, '{12'h000, 12'h000, 1'b1, 24'h000000, 24'h000000, 24'h000000, 4'd0},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'h001, 12'h000, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 4'd15},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'hFFF, 12'h001, 1'b0, 24'h800000, 24'h800000, 24'h800000, 4'd10},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'h002, 12'hFFF, 1'b0, 24'h000000, 24'h000000, 24'h000000, 4'd1},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'h003, 12'hFFF, 1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 4'd15},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'h003, 12'h003, 1'b0, 24'h800000, 24'h7FFFFF, 24'h800000, 4'd0},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'hAAA, 12'h002, 1'b1, 24'h555555, 24'hAAAAAA, 24'h555555, 4'hA},
      1'b1, CLIP_OUTSIDE},
    '{SET_ZERO, '{12'h555, 12'hAAA, 1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 4'h5},
      1'b1, CLIP_OUTSIDE},
    '{SET_HAND, '{12'd16, 12'd0, 1'b1, 24'h000000, 24'h000000, 24'h012C00, 4'd0},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd17, 12'd16, 1'b0, 24'h000000, 24'h000000, 24'h00C800, 4'd3},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd18, 12'd17, 1'b0, 24'h000000, 24'h000000, 24'h00C800, 4'd4},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd19, 12'd16, 1'b0, 24'h00C800, 24'h000000, 24'h012C00, 4'd3},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd20, 12'd19, 1'b0, 24'h00C800, 24'h000000, 24'h012C00, 4'd4},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd21, 12'd16, 1'b0, 24'h000000, 24'h000000, 24'hFFCE00, 4'd1},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd22, 12'd21, 1'b0, 24'h000000, 24'h001900, 24'hFFE700, 4'd12},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd23, 12'd0, 1'b1, 24'h000000, 24'h000000, 24'h04B000, 4'd2},
      1'b0, CLIP_NONE},
    '{SET_HAND, '{12'd24, 12'd23, 1'b0, 24'h000000, 24'h000000, 24'h04B000, 4'd3},
      1'b0, CLIP_NONE},
    '{SET_ONES, '{12'd30, 12'd16, 1'b1, 24'h800000, 24'h800000, 24'h800000, 4'd0},
      1'b0, CLIP_NONE},
    '{SET_ONES, '{12'd31, 12'd30, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 4'd0},
      1'b0, CLIP_NONE},
    '{SET_ONES, '{12'd32, 12'd31, 1'b0, 24'h000000, 24'h000000, 24'h000000, 4'd10},
      1'b0, CLIP_NONE},
    '{SET_EXTREME, '{12'd40, 12'd0, 1'b1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 4'd0},
      1'b0, CLIP_NONE},
    '{SET_EXTREME, '{12'd41, 12'd40, 1'b0, 24'h800000, 24'h800000, 24'h800000, 4'd0},
      1'b0, CLIP_NONE},
    '{SET_EXTREME, '{12'd42, 12'd41, 1'b0, 24'h000000, 24'h000000, 24'h000000, 4'd15},
      1'b0, CLIP_NONE},
    '{SET_EXTREME, '{12'd43, 12'd42, 1'b1, 24'h000000, 24'h000000, 24'h000000, 4'd10},
      1'b0, CLIP_NONE}
  };

  octree_frustum_visibility_top #(
    .NODE_COUNT(NODES),
    .MAX_DEPTH (DEPTH_MAX)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_node_index  (in_node_index),
    .in_parent_index(in_parent_index),
    .in_is_root     (in_is_root),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_center_z    (in_center_z),
    .in_depth       (in_depth),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_node_index (out_node_index),
    .out_clip_state (out_clip_state),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int w);
    return {w[27:0], nz[11:0], ny[11:0], nx[11:0]};
  endfunction

  function automatic logic [STATE_W-1:0] cube_clip(logic signed [COORD_W-1:0] cx,
                                                   logic signed [COORD_W-1:0] cy,
                                                   logic signed [COORD_W-1:0] cz,
                                                   int unsigned dep);
    longint ext, nx, ny, nz, w, s, r, lx, ly, lz, dot, reach, lo, hi, near_v, far_v;
    bit in_planes, out_any, in_part, outside;
    in_planes = 1'b1;
    out_any   = 1'b0;
    in_part   = 1'b0;
    outside   = 1'b0;
    ext = (longint'(extent_q) << 1) >> dep;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      nx = $signed(plane_q[i][11:0]);
      ny = $signed(plane_q[i][23:12]);
      nz = $signed(plane_q[i][35:24]);
      w  = $signed(plane_q[i][63:36]);
      s  = nx * cx + ny * cy + nz * cz + w * 1024;
      r  = ext * (mag(nx) + mag(ny) + mag(nz));
      if (s < -r) in_planes = 1'b0;
      if (s < r) out_any = 1'b1;
    end
    if (in_planes) begin
      lx     = $signed(look_q[15:0]);
      ly     = $signed(look_q[31:16]);
      lz     = $signed(look_q[47:32]);
      dot    = lx * cx + ly * cy + lz * cz;
      reach  = ext * (mag(lx) + mag(ly) + mag(lz));
      lo     = dot - reach;
      hi     = dot + reach;
      near_v = $signed(near_far_q[31:0]);
      far_v  = $signed(near_far_q[63:32]);
      near_v = near_v * 16384;
      far_v  = far_v * 16384;
      in_part = (hi > near_v) && (lo < far_v);
      outside = !in_part || (hi > far_v) || (lo < near_v);
    end
    outside = outside || out_any;
    return {outside, in_part};
  endfunction

  function automatic logic [STATE_W-1:0] classify_node(node_txn_t t);
    logic [STATE_W-1:0] ps;
    int unsigned dep;
    dep = (t.depth > DEPTH_MAX) ? DEPTH_MAX : t.depth;
    ps  = vis_shadow[t.parent];
    if (!t.root && (ps == CLIP_INSIDE || ps == CLIP_OUTSIDE)) return ps;
    return cube_clip($signed(t.cx), $signed(t.cy), $signed(t.cz), dep);
  endfunction

  task automatic send_node(node_txn_t t, bit typed, logic [STATE_W-1:0] typed_state);
    clip_result_t res;
    logic [STATE_W-1:0] st;
    in_valid        <= 1'b1;
    in_node_index   <= t.node;
    in_parent_index <= t.parent;
    in_is_root      <= t.root;
    in_center_x     <= t.cx;
    in_center_y     <= t.cy;
    in_center_z     <= t.cz;
    in_depth        <= t.depth;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    st = classify_node(t);
    vis_shadow[t.node] = st;
    if (!was_written[t.node]) begin
      was_written[t.node] = 1'b1;
      written_q = {written_q, t.node};
    end
    node_cx[t.node]    = $signed(t.cx);
    node_cy[t.node]    = $signed(t.cy);
    node_cz[t.node]    = $signed(t.cz);
    node_depth[t.node] = t.depth;
    res.node  = t.node;
    res.state = typed ? typed_state : st;
    clip_expect = {clip_expect, res};
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (clip_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(setting_t kind);
    logic [63:0] v [7];
    case (kind)
      SET_ZERO: foreach (v[i]) v[i] = '0;
      SET_ONES: foreach (v[i]) v[i] = '1;
      SET_EXTREME: begin
        v[REG_PLANE_LEFT]   = pack_plane(-2048, -2048, -2048, -134217728);
        v[REG_PLANE_RIGHT]  = pack_plane(2047, -2048, 0, -134217728);
        v[REG_PLANE_BOTTOM] = pack_plane(2047, 2047, 2047, 134217727);
        v[REG_PLANE_TOP]    = pack_plane(-2048, 2047, -2048, 134217727);
        v[REG_LOOK_AXIS]    = {16'h0, 16'h8000, 16'h7FFF, 16'h8000};
        v[REG_NEAR_FAR]     = {32'h7FFFFFFF, 32'h80000000};
        v[REG_WORLD_EXTENT] = 64'h7FFFFF;
      end
      SET_HAND: begin
        v[REG_PLANE_LEFT]   = pack_plane(1024, 0, 0, 25600);
        v[REG_PLANE_RIGHT]  = pack_plane(-1024, 0, 0, 25600);
        v[REG_PLANE_BOTTOM] = pack_plane(0, 1024, 0, 25600);
        v[REG_PLANE_TOP]    = pack_plane(0, -1024, 0, 25600);
        v[REG_LOOK_AXIS]    = {16'h0, 16'd16384, 16'd0, 16'd0};
        v[REG_NEAR_FAR]     = {32'd256000, 32'd256};
        v[REG_WORLD_EXTENT] = 64'd16384;
      end
      SET_TAME: begin
        v[REG_PLANE_LEFT]   = pack_plane(int'($urandom_range(300, 1024)), spread(200),
                                         int'($urandom_range(100, 600)),
                                         int'($urandom_range(0, 51200)));
        v[REG_PLANE_RIGHT]  = pack_plane(-int'($urandom_range(300, 1024)), spread(200),
                                         int'($urandom_range(100, 600)),
                                         int'($urandom_range(0, 51200)));
        v[REG_PLANE_BOTTOM] = pack_plane(spread(200), int'($urandom_range(300, 1024)),
                                         int'($urandom_range(100, 600)),
                                         int'($urandom_range(0, 51200)));
        v[REG_PLANE_TOP]    = pack_plane(spread(200), -int'($urandom_range(300, 1024)),
                                         int'($urandom_range(100, 600)),
                                         int'($urandom_range(0, 51200)));
        v[REG_LOOK_AXIS]    = {16'h0, 16'($urandom_range(9000, 16383)),
                               16'(spread(3000)), 16'(spread(3000))};
        v[REG_NEAR_FAR]     = {32'($urandom_range(51200, 512000)),
                               32'($urandom_range(0, 2560))};
        v[REG_WORLD_EXTENT] = 64'($urandom_range(4096, 131072));
      end
      default: foreach (v[i]) v[i] = {$urandom, $urandom};
    endcase
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= v[i];
      case (cfg_reg_t'(i))
        REG_LOOK_AXIS:    look_q = v[i][47:0];
        REG_NEAR_FAR:     near_far_q = v[i];
        REG_WORLD_EXTENT: extent_q = v[i][EXTENT_W-1:0];
        default:          plane_q[i] = v[i];
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    node_txn_t         t;
    setting_t          cur;
    logic [NODE_W-1:0] next_idx;
    logic [NODE_W-1:0] p;
    int                cxi, cyi, czi, half;
    bit                tree_item;
    foreach (plane_q[i]) plane_q[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = SET_ZERO;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur) begin
        settle();
        cur = dir_rows[i].setting;
        load_setting(cur);
      end
      send_node(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].state);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      load_setting(phase_plan[ph]);
      quiet    = (ph == PHASES - 1);
      idle_pct = quiet ? 0 : 15 * $urandom_range(0, 2);
      next_idx = 12'($urandom_range(0, NODES - 1));
      lineage.delete();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        tree_item = ($urandom_range(0, 99) < 80);
        if (tree_item) begin
          if (lineage.size() == 0 || $urandom_range(0, 99) < 8) begin
            t.root   = 1'b1;
            t.parent = written_q[$urandom_range(0, written_q.size() - 1)];
            t.depth  = 4'($urandom_range(0, 1));
            cxi = spread(76800);
            cyi = spread(76800);
            czi = int'($urandom_range(0, 409600)) - 25600;
            lineage.delete();
          end else begin
            t.root = 1'b0;
            p = $urandom_range(0, 1) ? lineage[$]
                                     : lineage[$urandom_range(0, lineage.size() - 1)];
            t.parent = p;
            t.depth  = (node_depth[p] == 4'd15) ? 4'd15 : node_depth[p] + 4'd1;
            half = (int'(extent_q) * 2) >> ((t.depth > DEPTH_MAX) ? DEPTH_MAX : t.depth);
            cxi = node_cx[p] + spread(half);
            cyi = node_cy[p] + spread(half);
            czi = node_cz[p] + spread(half);
          end
          t.node   = next_idx;
          next_idx = next_idx + 1'b1;
          t.cx = 24'(cxi);
          t.cy = 24'(cyi);
          t.cz = 24'(czi);
        end else begin
          t.node   = 12'($urandom_range(0, NODES - 1));
          t.parent = written_q[$urandom_range(0, written_q.size() - 1)];
          t.root   = 1'($urandom_range(0, 1));
          t.cx     = 24'($urandom);
          t.cy     = 24'($urandom);
          t.cz     = 24'($urandom);
          t.depth  = 4'($urandom_range(0, 15));
        end
        send_node(t, 1'b0, CLIP_NONE);
        if (tree_item) begin
          lineage = {lineage, t.node};
          if (lineage.size() > 48) void'(lineage.pop_front());
        end
      end
    end

    in_valid <= 1'b0;
    while (clip_expect.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("octree_frustum_visibility_top_tb passed");
    end else begin
      $display("octree_frustum_visibility_top_tb failed");
    end
    $finish;
  end

  // result side: checks every transaction and throttles out_ready
  initial begin
    clip_result_t want;
    int rx_count;
    int stall_left;
    int hold_left;
    int stall_pct;
    rx_count   = 0;
    stall_left = 0;
    hold_left  = 0;
    stall_pct  = 20;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (clip_expect.size() == 0) begin
          $error("result for node %0h with nothing expected", out_node_index);
          fail_count++;
        end else begin
          want = clip_expect.pop_front();
          if (out_node_index !== want.node) begin
            $error("out_node_index expected %0h actual %0h", want.node, out_node_index);
            fail_count++;
          end
          if (out_clip_state !== want.state) begin
            $error("clip_state expected %0b actual %0b", want.state, out_clip_state);
            fail_count++;
          end
        end
        rx_count++;
        if (rx_count == 400 || rx_count == 1000) hold_left = 300;
        if (rx_count % 50 == 0) stall_pct = 20 * $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #400us;
    $display("octree_frustum_visibility_top_tb failed");
    $finish;
  end

endmodule

/* octree_frustum_visibility_top.f */
rtl/core/ofv_pkg.sv
rtl/core/ofv_ram.sv
rtl/core/ofv_cfg.sv
rtl/core/ofv_clip.sv
rtl/core/octree_frustum_visibility_top.sv
rtl/core/ofv_checker.sv
test/octree_frustum_visibility_top_tb.sv
